// ===== rtl/core/hdt_pkg.sv =====
// Shared types and constants for the haversine distance block.
// No dependencies; every other file in rtl/core imports this package.
package hdt_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int ATAN_LEN         = 31;
  localparam int CW               = 34;  // CORDIC datapath width
  localparam int SQ_STEPS         = 31;  // root digits for a 61-bit radicand

  typedef logic signed [CW-1:0] cval_t;

  // atan(2^-i) in Q30, truncated
  localparam cval_t ATAN_Q30 [ATAN_LEN] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
    34'sd33543515, 34'sd16775850, 34'sd8388437, 34'sd4194282, 34'sd2097149,
    34'sd1048575, 34'sd524287, 34'sd262143, 34'sd131071, 34'sd65535,
    34'sd32767, 34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
    34'sd1023, 34'sd511, 34'sd255, 34'sd127, 34'sd63,
    34'sd31, 34'sd15, 34'sd7, 34'sd3, 34'sd1, 34'sd0
  };

  localparam cval_t       INV_GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  // ceil(2^43 / 45): exact quotient by 45 for dividends below 2^37
  localparam logic [37:0] RECIP45      = 38'd195468733827;
  localparam int          RECIP_SHIFT  = 43;

  localparam logic [1:0] CFG_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_REF_LAT = 2'd1;
  localparam logic [1:0] CFG_REF_LON = 2'd2;

  typedef struct packed {
    logic signed [30:0] fix_latitude;
    logic signed [31:0] fix_longitude;
  } in_word_t;

  typedef struct packed {
    logic [28:0] distance_sixteenths;
    logic        distance_valid;
  } out_word_t;

  typedef struct packed {
    logic vld;
    logic en;
    logic neg;
  } ctl_t;

endpackage

// ===== rtl/core/haversine_distance_to_reference.sv =====
// Top level: great-circle distance from each fix to the configured reference.
// Uses hdt_pkg, hdt_to_rad, hdt_rot_cell, hdt_sqrt_cell and hdt_vec_cell.
//
// Takes one fix per clock: busy is always low, and each fix gives exactly one
// word on out_word, strobed by out_strobe for a single cycle. With N =
// min(CORDIC_STEPS, 31), the latency is the depth of the pipeline: the
// N-cell sine/cosine chains, the 31-cell root chains and the N-cell arcsine
// chain dominate it. Results cannot be held off, so the receiver must take
// every strobed word. Write the reference registers only while no fix is in
// flight; a word with distance_valid low and zero distance is given when
// the reference is disabled.
module haversine_distance_to_reference #(
  parameter int CORDIC_STEPS = hdt_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hdt_pkg::in_word_t in_word,
  output logic              out_strobe,
  output hdt_pkg::out_word_t out_word,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import hdt_pkg::*;

  localparam int NS      = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int CTL_LEN = 45 + 2 * NS;

  localparam logic signed [33:0] DEG90  = 34'sd754974720;
  localparam logic signed [33:0] DEG180 = 34'sd1509949440;
  localparam logic signed [33:0] DEG360 = 34'sd3019898880;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  function automatic logic signed [33:0] wrap_deg(input logic signed [33:0] d);
    logic signed [33:0] w;
    w = d;
    if (d >= DEG180) w = d - DEG360;
    else if (d < -DEG180) w = d + DEG360;
    return w;
  endfunction

  // Q60 -> Q30, half away from zero; flip negates the result
  function automatic logic signed [33:0] rnd_q60(input logic signed [63:0] p,
                                                 input logic flip);
    logic [63:0] mag;
    logic [33:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    r   = 34'((mag + 64'd536870912) >> 30);
    return (p[63] ^ flip) ? -signed'(r) : signed'(r);
  endfunction

  // configuration
  logic               ref_en_r;
  logic signed [30:0] ref_lat_r;
  logic signed [31:0] ref_lon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_en_r  <= 1'b0;
      ref_lat_r <= '0;
      ref_lon_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:  ref_en_r  <= cfg_data[0];
        CFG_REF_LAT: ref_lat_r <= signed'(cfg_data[30:0]);
        CFG_REF_LON: ref_lon_r <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // control shift line, one entry per pipeline stage
  ctl_t ctl_r [CTL_LEN];
  logic neg3;

  // the cosine sign joins the line as the word leaves the latitude fold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CTL_LEN; k++) ctl_r[k] <= '0;
    end else begin
      ctl_r[0] <= '{vld: start & ~busy, en: ref_en_r, neg: 1'b0};
      for (int k = 1; k < CTL_LEN; k++) begin
        if (k == 3) ctl_r[k] <= '{vld: ctl_r[2].vld, en: ctl_r[2].en, neg: neg3};
        else        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // stages 1 to 3: differences, wrap, magnitudes, latitude fold
  logic signed [33:0] dlat1_r, dlon1_r, dlat2_r, dlon2_r;
  logic signed [30:0] lf1_r, lr1_r;
  logic [30:0]        mf2_r, mr2_r;
  logic [30:0]        mdlat3_r, mdlon3_r, mf3_r, mr3_r;
  logic               nf3_r, nr3_r;
  logic signed [31:0] lf_w, lr_w;
  logic signed [33:0] dlat_abs, dlon_abs;

  assign lf_w     = 32'(lf1_r);
  assign lr_w     = 32'(lr1_r);
  assign dlat_abs = dlat2_r[33] ? -dlat2_r : dlat2_r;
  assign dlon_abs = dlon2_r[33] ? -dlon2_r : dlon2_r;
  assign neg3     = nf3_r ^ nr3_r;

  always_ff @(posedge clk) begin
    dlat1_r <= 34'(ref_lat_r) - 34'(in_word.fix_latitude);
    dlon1_r <= 34'(ref_lon_r) - 34'(in_word.fix_longitude);
    lf1_r   <= in_word.fix_latitude;
    lr1_r   <= ref_lat_r;

    dlat2_r <= wrap_deg(dlat1_r);
    dlon2_r <= wrap_deg(dlon1_r);
    mf2_r   <= lf_w[31] ? 31'(-lf_w) : lf_w[30:0];
    mr2_r   <= lr_w[31] ? 31'(-lr_w) : lr_w[30:0];

    mdlat3_r <= dlat_abs[30:0];
    mdlon3_r <= dlon_abs[30:0];
    nf3_r    <= 34'(mf2_r) > DEG90;
    nr3_r    <= 34'(mr2_r) > DEG90;
    mf3_r    <= (34'(mf2_r) > DEG90) ? 31'(DEG180 - 34'(mf2_r)) : mf2_r;
    mr3_r    <= (34'(mr2_r) > DEG90) ? 31'(DEG180 - 34'(mr2_r)) : mr2_r;
  end

  // stages 4 to 7: radians. Lanes: 0 half dlat, 1 half dlon, 2 fix lat, 3 ref lat
  logic [30:0] rad [4];

  hdt_to_rad #(.SHIFT(26)) u_rad0 (.clk(clk), .mag_i(mdlat3_r), .rad_o(rad[0]));
  hdt_to_rad #(.SHIFT(26)) u_rad1 (.clk(clk), .mag_i(mdlon3_r), .rad_o(rad[1]));
  hdt_to_rad #(.SHIFT(25)) u_rad2 (.clk(clk), .mag_i(mf3_r),    .rad_o(rad[2]));
  hdt_to_rad #(.SHIFT(25)) u_rad3 (.clk(clk), .mag_i(mr3_r),    .rad_o(rad[3]));

  // sine/cosine chains
  cval_t rx [4][NS+1];
  cval_t ry [4][NS+1];
  cval_t rz [4][NS+1];

  for (genvar ln = 0; ln < 4; ln++) begin : g_rot
    assign rx[ln][0] = INV_GAIN_Q30;
    assign ry[ln][0] = '0;
    assign rz[ln][0] = cval_t'({3'b0, rad[ln]});
    for (genvar st = 0; st < NS; st++) begin : g_cell
      hdt_rot_cell #(.STEP(st)) u_cell (
        .clk(clk),
        .x_i(rx[ln][st]), .y_i(ry[ln][st]), .z_i(rz[ln][st]),
        .x_o(rx[ln][st+1]), .y_o(ry[ln][st+1]), .z_o(rz[ln][st+1])
      );
    end
  end

  // combine: a = sin^2(dlat/2) + sin^2(dlon/2) * cos(lat) * cos(ref lat)
  logic signed [63:0] sq1_r, sq2_r, cp_r, p2_r;
  logic signed [33:0] s1_r, s2_r, cc_r, s1d_r, s1e_r, r2_r, asum_r;
  logic [60:0]        opy_r, opx_r;
  logic [30:0]        a_cl, a_cmp;

  assign a_cl  = asum_r[33] ? 31'd0 : (asum_r > ONE_Q30) ? ONE_Q30[30:0] : asum_r[30:0];
  assign a_cmp = 31'(ONE_Q30[30:0] - a_cl);

  always_ff @(posedge clk) begin
    sq1_r  <= signed'(ry[0][NS][31:0]) * signed'(ry[0][NS][31:0]);
    sq2_r  <= signed'(ry[1][NS][31:0]) * signed'(ry[1][NS][31:0]);
    cp_r   <= signed'(rx[2][NS][31:0]) * signed'(rx[3][NS][31:0]);
    s1_r   <= rnd_q60(sq1_r, 1'b0);
    s2_r   <= rnd_q60(sq2_r, 1'b0);
    cc_r   <= rnd_q60(cp_r, ctl_r[7+NS].neg);
    p2_r   <= signed'(s2_r[31:0]) * signed'(cc_r[31:0]);
    s1d_r  <= s1_r;
    r2_r   <= rnd_q60(p2_r, 1'b0);
    s1e_r  <= s1d_r;
    asum_r <= s1e_r + r2_r;
    opy_r  <= {a_cl, 30'b0};
    opx_r  <= {a_cmp, 30'b0};
  end

  // square roots: lane 0 sqrt(a), lane 1 sqrt(1 - a)
  logic [60:0] sv [2][SQ_STEPS+1];
  logic [61:0] sr [2][SQ_STEPS+1];

  assign sv[0][0] = opy_r;
  assign sv[1][0] = opx_r;

  for (genvar ln = 0; ln < 2; ln++) begin : g_sqrt
    assign sr[ln][0] = '0;
    for (genvar st = 0; st < SQ_STEPS; st++) begin : g_cell
      hdt_sqrt_cell #(.STEP(st)) u_cell (
        .clk(clk),
        .v_i(sv[ln][st]), .r_i(sr[ln][st]),
        .v_o(sv[ln][st+1]), .r_o(sr[ln][st+1])
      );
    end
  end

  // arcsine via vectoring on (sqrt(1-a), sqrt(a))
  cval_t vx [NS+1];
  cval_t vy [NS+1];
  cval_t vz [NS+1];

  assign vx[0] = cval_t'({3'b0, sr[1][SQ_STEPS][30:0]});
  assign vy[0] = cval_t'({3'b0, sr[0][SQ_STEPS][30:0]});
  assign vz[0] = '0;

  for (genvar st = 0; st < NS; st++) begin : g_vec
    hdt_vec_cell #(.STEP(st)) u_cell (
      .clk(clk),
      .x_i(vx[st]), .y_i(vy[st]), .z_i(vz[st]),
      .x_o(vx[st+1]), .y_o(vy[st+1]), .z_o(vz[st+1])
    );
  end

  // scale to sixteenths of a metre and saturate
  logic [58:0] dprod_r;
  logic [30:0] zc;
  logic [29:0] scaled;
  logic        out_strobe_r;
  out_word_t   out_word_r;

  assign zc     = vz[NS][CW-1] ? 31'd0 : vz[NS][30:0];
  assign scaled = 30'((dprod_r + 59'd536870912) >> 30);

  always_ff @(posedge clk) begin
    dprod_r    <= 59'(zc) * 59'd203872000;
    out_word_r <= '{distance_sixteenths: !ctl_r[CTL_LEN-1].en ? 29'd0 :
                                         scaled[29] ? {29{1'b1}} : scaled[28:0],
                    distance_valid:      ctl_r[CTL_LEN-1].en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= ctl_r[CTL_LEN-1].vld;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// ===== rtl/core/hdt_to_rad.sv =====
// Degree magnitude (2^-23 deg) to Q30 radians, rounded, four pipeline stages.
// Divides by 45 * 2^SHIFT via a shift and a split reciprocal multiply. Uses hdt_pkg.
module hdt_to_rad #(
  parameter int SHIFT = 25
) (
  input  logic        clk,
  input  logic [30:0] mag_i,
  output logic [30:0] rad_o
);
  import hdt_pkg::*;

  localparam logic [62:0] HALF_DEN = 63'(45) << (SHIFT - 1);

  logic [62:0] prod_r;
  logic [36:0] quo_r;
  logic [56:0] plo_r;
  logic [55:0] phi_r;
  logic [30:0] rad_r;
  logic [74:0] sum;

  assign sum = {phi_r, 19'b0} + 75'(plo_r);

  always_ff @(posedge clk) begin
    prod_r <= 63'(mag_i) * 63'(PI_Q30);
    quo_r  <= 37'((prod_r + HALF_DEN) >> SHIFT);
    plo_r  <= 57'(quo_r[18:0]) * 57'(RECIP45);
    phi_r  <= 56'(quo_r[36:19]) * 56'(RECIP45);
    rad_r  <= sum[RECIP_SHIFT+30:RECIP_SHIFT];
  end

  assign rad_o = rad_r;

endmodule

// ===== rtl/core/hdt_rot_cell.sv =====
// One rotation-mode CORDIC iteration, registered.
// Uses hdt_pkg for the arctangent table and datapath width.
module hdt_rot_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  hdt_pkg::cval_t       x_i,
  input  hdt_pkg::cval_t       y_i,
  input  hdt_pkg::cval_t       z_i,
  output hdt_pkg::cval_t       x_o,
  output hdt_pkg::cval_t       y_o,
  output hdt_pkg::cval_t       z_o
);
  import hdt_pkg::*;

  localparam cval_t ANG = ATAN_Q30[STEP];

  cval_t x_r, y_r, z_r;
  cval_t dx, dy;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_ff @(posedge clk) begin
    if (!z_i[CW-1]) begin
      x_r <= x_i - dx;
      y_r <= y_i + dy;
      z_r <= z_i - ANG;
    end else begin
      x_r <= x_i + dx;
      y_r <= y_i - dy;
      z_r <= z_i + ANG;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// ===== rtl/core/hdt_vec_cell.sv =====
// One vectoring-mode CORDIC iteration, registered; z collects the angle.
// Uses hdt_pkg for the arctangent table and datapath width.
module hdt_vec_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  hdt_pkg::cval_t       x_i,
  input  hdt_pkg::cval_t       y_i,
  input  hdt_pkg::cval_t       z_i,
  output hdt_pkg::cval_t       x_o,
  output hdt_pkg::cval_t       y_o,
  output hdt_pkg::cval_t       z_o
);
  import hdt_pkg::*;

  localparam cval_t ANG = ATAN_Q30[STEP];

  cval_t x_r, y_r, z_r;
  cval_t dx, dy;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_ff @(posedge clk) begin
    if (y_i > 0) begin
      x_r <= x_i + dx;
      y_r <= y_i - dy;
      z_r <= z_i + ANG;
    end else begin
      x_r <= x_i - dx;
      y_r <= y_i + dy;
      z_r <= z_i - ANG;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// ===== rtl/core/hdt_sqrt_cell.sv =====
// One digit of a restoring binary square root, registered.
// Radicand remainder and partial root pass to the next cell. Uses hdt_pkg.
module hdt_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic [60:0] v_i,
  input  logic [61:0] r_i,
  output logic [60:0] v_o,
  output logic [61:0] r_o
);
  import hdt_pkg::*;

  localparam logic [61:0] BIT = 62'(1) << (2 * (SQ_STEPS - 1 - STEP));

  logic [60:0] v_r;
  logic [61:0] r_r;
  logic [61:0] trial;

  assign trial = r_i + BIT;

  always_ff @(posedge clk) begin
    if ({1'b0, v_i} >= trial) begin
      v_r <= v_i - trial[60:0];
      r_r <= (r_i >> 1) + BIT;
    end else begin
      v_r <= v_i;
      r_r <= r_i >> 1;
    end
  end

  assign v_o = v_r;
  assign r_o = r_r;

endmodule

// ===== dv/haversine_distance_to_reference_tb.sv =====
// Self-checking testbench for haversine_distance_to_reference.
// Needs hdt_pkg and the block; a bit-exact distance predictor is held locally.
`timescale 1ns / 1ps

module haversine_distance_to_reference_tb;
  import hdt_pkg::*;

  localparam int     LATENCY   = 46 + 2 * 24;
  localparam int     WDOG_MAX  = 5000;
  localparam int     ROT_STEPS = (CORDIC_STEPS_DEF < 31) ? CORDIC_STEPS_DEF : 31;
  localparam longint DEG90     = 64'sd754974720;
  localparam longint DEG180    = 64'sd1509949440;
  localparam longint DEG360    = 64'sd3019898880;
  localparam longint ONE_Q30   = 64'sd1073741824;
  localparam longint HALF_Q30  = 64'sd536870912;
  localparam longint PI_Q30_L  = 64'sd3373259426;
  localparam longint GAIN_INV  = 64'sd652032874;
  localparam longint SIXT_2R   = 64'sd203872000;
  localparam longint DIST_MAX  = 64'sd536870911;

  localparam longint ATAN_TAB [31] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 7, 3, 1, 0
  };

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_strobe;
  out_word_t out_word;
  logic      cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  haversine_distance_to_reference i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // local copy of the reference registers
  bit     ref_on;
  longint ref_lat;
  longint ref_lon;

  in_word_t  pending_fixes[$];
  out_word_t expected_dists[$];
  int        send_idle_pct;
  int        n_fixes, n_dists, n_errors, wdog;

  function automatic longint round_q30(longint p);
    if (p >= 0) return (p + HALF_Q30) >>> 30;
    return -((-p + HALF_Q30) >>> 30);
  endfunction

  function automatic longint wrap_angle(longint d);
    longint t;
    t = d + DEG180 + 4 * DEG360;
    return (t % DEG360) - DEG180;
  endfunction

  function automatic longint deg_to_rad(longint mag, longint den);
    longint unsigned m, dn;
    m  = mag;
    dn = den;
    return longint'((m * longint'(PI_Q30_L) + dn / 2) / dn);
  endfunction

  function automatic void cordic_rotate(longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = GAIN_INV;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint half_sine_sq(longint d);
    longint t, m, c, s;
    t = wrap_angle(d);
    m = (t < 0) ? -t : t;
    cordic_rotate(deg_to_rad(m, 2 * DEG180), c, s);
    return round_q30(s * s);
  endfunction

  function automatic longint lat_cosine(longint lat);
    longint t, m, c, s;
    bit     flip;
    t = wrap_angle(lat);
    m = (t < 0) ? -t : t;
    flip = 0;
    if (m > DEG90) begin
      m = DEG180 - m;
      flip = 1;
    end
    cordic_rotate(deg_to_rad(m, DEG180), c, s);
    return flip ? -c : c;
  endfunction

  function automatic out_word_t great_circle_dist(in_word_t fix);
    out_word_t r;
    longint lat, lon, s1, s2, cc, a, sy, sx, z, d;
    lat = longint'(fix.fix_latitude);
    lon = longint'(fix.fix_longitude);
    r = '0;
    if (!ref_on) return r;
    s1 = half_sine_sq(ref_lat - lat);
    s2 = half_sine_sq(ref_lon - lon);
    cc = round_q30(lat_cosine(lat) * lat_cosine(ref_lat));
    a  = s1 + round_q30(s2 * cc);
    if (a < 0) a = 0;
    if (a > ONE_Q30) a = ONE_Q30;
    sy = int_sqrt(longint'(a) << 30);
    sx = int_sqrt(longint'(ONE_Q30 - a) << 30);
    z  = cordic_angle(sx, sy);
    if (z < 0) z = 0;
    d = (z * SIXT_2R + HALF_Q30) >>> 30;
    if (d > DIST_MAX) d = DIST_MAX;
    r.distance_sixteenths = d[28:0];
    r.distance_valid      = 1'b1;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: one word per accepted start
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_dists.push_back(great_circle_dist(in_word));
        n_fixes++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_fixes.size() != 0 &&
                   $urandom_range(99, 0) >= send_idle_pct) begin
        in_word <= pending_fixes.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      n_dists++;
      if (expected_dists.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_word);
        n_errors++;
      end else begin
        out_word_t e;
        e = expected_dists.pop_front();
        if (e.distance_sixteenths !== out_word.distance_sixteenths) begin
          $display("%0t: distance_sixteenths exp %0d got %0d", $time,
                   e.distance_sixteenths, out_word.distance_sixteenths);
          n_errors++;
        end
        if (e.distance_valid !== out_word.distance_valid) begin
          $display("%0t: distance_valid exp %0b got %0b", $time,
                   e.distance_valid, out_word.distance_valid);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("%0t: watchdog expired", $time);
      $display("Test completed with failures");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input longint val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[31:0];
    case (idx)
      CFG_ENABLE:  ref_on  = val[0];
      CFG_REF_LAT: ref_lat = longint'($signed(val[30:0]));
      CFG_REF_LON: ref_lon = longint'($signed(val[31:0]));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (pending_fixes.size() != 0 || start || expected_dists.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic add_fix(input longint lat, input longint lon);
    in_word_t w;
    w.fix_latitude  = lat[30:0];
    w.fix_longitude = lon[31:0];
    pending_fixes.push_back(w);
  endtask

  function automatic longint rand_lat();
    if ($urandom_range(9, 0) == 0) return longint'($signed($urandom()));
    return longint'($urandom_range(32'd1509949440, 0)) - DEG90;
  endfunction

  function automatic longint rand_lon();
    if ($urandom_range(9, 0) == 0) return longint'($signed($urandom()));
    return longint'($urandom_range(32'd3019898880, 0)) - DEG180;
  endfunction

  initial begin
    longint rl, rn;
    int     sc;
    rst_n = 1'b0; start = 1'b0; in_word = '0;
    cfg_we = 1'b0; cfg_index = CFG_ENABLE; cfg_data = '0;
    ref_on = 0; ref_lat = 0; ref_lon = 0;
    n_fixes = 0; n_dists = 0; n_errors = 0; wdog = 0;
    send_idle_pct = 25;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reference disabled after reset
    add_fix(0, 0);
    add_fix(DEG90, DEG180);
    drain();
    write_reg(CFG_ENABLE, 1);
    add_fix(0, 0);                       // zero distance
    add_fix(DEG90, 0);
    add_fix(-DEG90, 0);
    add_fix(0, DEG180);                  // antipode
    add_fix(0, -DEG180);
    add_fix(DEG90, DEG180);
    add_fix(-DEG90, -DEG180);
    add_fix(0, 64'sd2147483647);         // longitude difference past a half turn
    add_fix(0, -64'sd2147483648);
    add_fix(64'sd1073741823, 0);         // latitude beyond the pole, negative cosine
    add_fix(-64'sd1073741824, 12345);
    add_fix(64'sd1000000000, -64'sd1000000000);
    add_fix(1, 1);
    drain();
    write_reg(CFG_REF_LAT, DEG90);
    write_reg(CFG_REF_LON, -DEG180);
    add_fix(-DEG90, DEG180);
    add_fix(DEG90, 0);
    add_fix(0, 0);
    add_fix(-64'sd1073741824, 64'sd2147483647);
    drain();
    write_reg(CFG_REF_LAT, -DEG90);
    write_reg(CFG_REF_LON, DEG180);
    add_fix(DEG90, -DEG180);
    add_fix(-DEG90, DEG180);
    add_fix(64'sd1073741823, -64'sd2147483648);
    drain();

    // random blocks, each with its own reference; mostly fixes near it
    for (int blk = 0; blk < 9; blk++) begin
      send_idle_pct = (blk < 3) ? 25 : (blk < 6) ? 64 : 0;
      write_reg(CFG_ENABLE, (blk == 4) ? 0 : 1);
      rl = (blk == 2) ? DEG90 : (blk == 7) ? -DEG90 : rand_lat();
      rn = (blk == 2) ? DEG180 : (blk == 7) ? -DEG180 : rand_lon();
      write_reg(CFG_REF_LAT, rl);
      write_reg(CFG_REF_LON, rn);
      for (int k = 0; k < 128; k++) begin
        if ($urandom_range(2, 0) != 0) begin
          sc = $urandom_range(28, 4);
          add_fix(ref_lat + longint'($signed($urandom())) / (64'sd1 << (32 - sc)),
                  ref_lon + longint'($signed($urandom())) / (64'sd1 << (32 - sc)));
        end else begin
          add_fix(rand_lat(), rand_lon());
        end
      end
      drain();
    end

    $display("Checked %0d fixes against %0d distance words across 11 reference settings",
             n_fixes, n_dists);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
